@@ rtl/core/typed_snapshot_diff_filter_macros.svh @@
// ----------------------------------------------------------------------------
// Typed snapshot diff filter: assertion macros
// Clocked assertion helpers shared by the RTL. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TYPED_SNAPSHOT_DIFF_FILTER_MACROS_SVH
`define TYPED_SNAPSHOT_DIFF_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Plain property sampled on clk, disabled during reset.
`define TSDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication sampled on clk, disabled during reset.
`define TSDF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication sampled on clk, disabled during reset.
`define TSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TSDF_ASSERT(lbl, prop, msg)
`define TSDF_ASSERT_IMP(lbl, ante, cons, msg)
`define TSDF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/tsdf_pkg.sv @@
// ----------------------------------------------------------------------------
// Typed snapshot diff filter package
// Types, codes and constants shared by the filter's modules.
// ----------------------------------------------------------------------------
package tsdf_pkg;

	// Size of the scanned region in bytes; an element must end inside it.
	localparam logic [32:0] REGION_BYTES = 33'd16777216;

	// Width of the configuration register index.
	localparam int CFG_INDEX_W = 3;

	// Scan modes. Codes above the stabilized mode never match.
	typedef enum logic [3:0] {
		MODE_CHANGED    = 4'd0,
		MODE_UNCHANGED  = 4'd1,
		MODE_INCREASED  = 4'd2,
		MODE_DECREASED  = 4'd3,
		MODE_INC_BY     = 4'd4,
		MODE_DEC_BY     = 4'd5,
		MODE_EXACT      = 4'd6,
		MODE_RANGE      = 4'd7,
		MODE_MASK       = 4'd8,
		MODE_STABILIZED = 4'd9
	} scan_mode_t;

	// Element data types. The unused code behaves as an unsigned byte.
	typedef enum logic [2:0] {
		DT_S8  = 3'd0,
		DT_U8  = 3'd1,
		DT_S16 = 3'd2,
		DT_U16 = 3'd3,
		DT_S32 = 3'd4,
		DT_U32 = 3'd5,
		DT_F32 = 3'd6
	} data_type_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCAN_MODE    = 3'd0,
		REG_DATA_TYPE    = 3'd1,
		REG_VALUE_A      = 3'd2,
		REG_VALUE_B      = 3'd3,
		REG_MASK_BITS    = 3'd4,
		REG_PATTERN_BITS = 3'd5
	} cfg_index_t;

	// Current configuration as seen by the pipeline.
	typedef struct packed {
		scan_mode_t  scan_mode;
		data_type_t  data_type;
		logic [63:0] value_a;
		logic [63:0] value_b;
		logic [31:0] mask_bits;
		logic [31:0] pattern_bits;
	} cfg_t;

	// Compare results handed from the compare stage to the select stage.
	typedef struct packed {
		logic ne;
		logic gt;
		logic lt;
		logic eq_a;
		logic ge_a;
		logic le_b;
		logic mask_ok;
	} cmp_flags_t;

endpackage

@@ rtl/core/tsdf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Typed snapshot diff filter: configuration registers
// Holds the scan mode, data type and compare operands written over the
// configuration channel.
// ----------------------------------------------------------------------------
module tsdf_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tsdf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data,
	output tsdf_pkg::cfg_t                  cfg
);

	tsdf_pkg::cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register file; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_mode    <= tsdf_pkg::MODE_CHANGED;
			cfg_q.data_type    <= tsdf_pkg::DT_F32;
			cfg_q.value_a      <= '0;
			cfg_q.value_b      <= '0;
			cfg_q.mask_bits    <= '0;
			cfg_q.pattern_bits <= '0;
		end else if (cfg_valid) begin
			case (tsdf_pkg::cfg_index_t'(cfg_index))
				tsdf_pkg::REG_SCAN_MODE: begin
					cfg_q.scan_mode <= tsdf_pkg::scan_mode_t'(cfg_data[3:0]);
				end
				tsdf_pkg::REG_DATA_TYPE: begin
					cfg_q.data_type <= tsdf_pkg::data_type_t'(cfg_data[2:0]);
				end
				tsdf_pkg::REG_VALUE_A: begin
					cfg_q.value_a <= cfg_data;
				end
				tsdf_pkg::REG_VALUE_B: begin
					cfg_q.value_b <= cfg_data;
				end
				tsdf_pkg::REG_MASK_BITS: begin
					cfg_q.mask_bits <= cfg_data[31:0];
				end
				tsdf_pkg::REG_PATTERN_BITS: begin
					cfg_q.pattern_bits <= cfg_data[31:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/tsdf_widen_stage.sv @@
// ----------------------------------------------------------------------------
// Typed snapshot diff filter: widen stage
// First pipeline stage. Extends both raw words to 64 bits by data type and
// drops elements that run past the end of the region.
// ----------------------------------------------------------------------------
`include "typed_snapshot_diff_filter_macros.svh"

module tsdf_widen_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          before_word,
	input  logic [31:0]          after_word,
	input  logic [23:0]          element_offset,
	input  tsdf_pkg::cfg_t       cfg,
	input  logic                 next_ready,
	output logic                 valid_s1,
	output logic [23:0]          offset_s1,
	output logic [63:0]          before_s1,
	output logic [63:0]          after_s1,
	output tsdf_pkg::scan_mode_t mode_s1
);

	// Extends a raw little-endian word by data type.
	function automatic logic [63:0] widen(input logic [31:0] raw,
			input tsdf_pkg::data_type_t t);
		logic [63:0] v;
		case (t)
			tsdf_pkg::DT_S8:  v = {{56{raw[7]}}, raw[7:0]};
			tsdf_pkg::DT_S16: v = {{48{raw[15]}}, raw[15:0]};
			tsdf_pkg::DT_U16: v = {48'b0, raw[15:0]};
			tsdf_pkg::DT_S32: v = {{32{raw[31]}}, raw};
			tsdf_pkg::DT_U32: v = {32'b0, raw};
			tsdf_pkg::DT_F32: v = {32'b0, raw};
			default:          v = {56'b0, raw[7:0]};
		endcase
		return v;
	endfunction

	// Element size in bytes by data type.
	function automatic logic [2:0] elem_bytes(input tsdf_pkg::data_type_t t);
		logic [2:0] n;
		case (t)
			tsdf_pkg::DT_S16, tsdf_pkg::DT_U16: n = 3'd2;
			tsdf_pkg::DT_S32, tsdf_pkg::DT_U32, tsdf_pkg::DT_F32: n = 3'd4;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

	logic        ready_s1;
	logic        in_region;
	logic [32:0] end_byte;

	// The stage takes a beat when it is empty or its content moves on.
	assign ready_s1 = !valid_s1 || next_ready;
	assign in_ready = ready_s1;

	// Element end must not pass the region end.
	assign end_byte  = {9'b0, element_offset} + {30'b0, elem_bytes(cfg.data_type)};
	assign in_region = (end_byte <= tsdf_pkg::REGION_BYTES);

	// Valid bit; out-of-region elements leave a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid && in_region;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			offset_s1 <= element_offset;
			before_s1 <= widen(before_word, cfg.data_type);
			after_s1  <= widen(after_word, cfg.data_type);
			mode_s1   <= cfg.scan_mode;
		end
	end

	// A widened value always has an upper half of all zeros or all ones.
	`TSDF_ASSERT_IMP(a_widen_upper, valid_s1,
		(after_s1[63:32] == '0) || (after_s1[63:32] == '1),
		"widened value has a mixed upper half")

	// A held beat keeps its data while the next stage is full.
	`TSDF_ASSERT_NEXT(a_widen_hold, valid_s1 && !next_ready,
		valid_s1 && $stable(after_s1) && $stable(offset_s1),
		"widen stage lost or changed a stalled beat")

endmodule

@@ rtl/core/tsdf_compare_stage.sv @@
// ----------------------------------------------------------------------------
// Typed snapshot diff filter: compare stage
// Second pipeline stage. Forms both wrapped differences and the relational
// and operand compares needed by every scan mode.
// ----------------------------------------------------------------------------
`include "typed_snapshot_diff_filter_macros.svh"

module tsdf_compare_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	output logic                 ready_s1,
	input  logic [23:0]          offset_s1,
	input  logic [63:0]          before_s1,
	input  logic [63:0]          after_s1,
	input  tsdf_pkg::scan_mode_t mode_s1,
	input  tsdf_pkg::cfg_t       cfg,
	input  logic                 next_ready,
	output logic                 valid_s2,
	output logic [23:0]          offset_s2,
	output logic [63:0]          before_s2,
	output logic [63:0]          after_s2,
	output tsdf_pkg::scan_mode_t mode_s2,
	output logic [63:0]          diff_ab_s2,
	output logic [63:0]          diff_ba_s2,
	output tsdf_pkg::cmp_flags_t flags_s2
);

	logic                 ready_s2;
	tsdf_pkg::cmp_flags_t flags;

	assign ready_s2 = !valid_s2 || next_ready;
	assign ready_s1 = ready_s2;

	// Unsigned 64-bit compares on the widened values; the mask test uses the low 32 bits.
	always_comb begin
		flags.ne      = (before_s1 != after_s1);
		flags.gt      = (after_s1 > before_s1);
		flags.lt      = (after_s1 < before_s1);
		flags.eq_a    = (after_s1 == cfg.value_a);
		flags.ge_a    = (after_s1 >= cfg.value_a);
		flags.le_b    = (after_s1 <= cfg.value_b);
		flags.mask_ok = ((after_s1[31:0] & cfg.mask_bits) == cfg.pattern_bits);
	end

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Payload and compare results.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			offset_s2  <= offset_s1;
			before_s2  <= before_s1;
			after_s2   <= after_s1;
			mode_s2    <= mode_s1;
			diff_ab_s2 <= after_s1 - before_s1;
			diff_ba_s2 <= before_s1 - after_s1;
			flags_s2   <= flags;
		end
	end

	// Greater and less never hold together, and both imply a change.
	`TSDF_ASSERT_IMP(a_cmp_order, valid_s2,
		!(flags_s2.gt && flags_s2.lt) && ((flags_s2.gt || flags_s2.lt) == flags_s2.ne),
		"inconsistent ordering flags")

	// The two differences are negatives of each other.
	`TSDF_ASSERT_IMP(a_cmp_diff, valid_s2,
		(diff_ab_s2 + diff_ba_s2) == 64'd0,
		"wrapped differences disagree")

endmodule

@@ rtl/core/typed_snapshot_diff_filter.sv @@
// ----------------------------------------------------------------------------
// Typed snapshot diff filter
// Widens a before/after element pair by data type, tests it in the chosen
// scan mode and passes on the offset and both values of each match.
// ----------------------------------------------------------------------------
// The filter takes one element beat per clock and has three register stages:
// widen and region check, compare, then mode select into the output register.
// A matching element passes the widen, compare and output registers in turn
// before it reaches the output. Elements that do not match, or that run past
// the region end, leave no beat.
// Throughput is one element per cycle as long as the output side keeps up;
// a stalled output fills the three stages before in_ready drops. Configuration
// writes are taken at once and should be done only while the pipeline is empty.
// ----------------------------------------------------------------------------
module typed_snapshot_diff_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsdf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [31:0]                      before_word,
	input  logic [31:0]                      after_word,
	input  logic [23:0]                      element_offset,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [23:0]                      match_offset,
	output logic [63:0]                      widened_before,
	output logic [63:0]                      widened_after
);

	tsdf_pkg::cfg_t       cfg;
	logic                 valid_s1;
	logic                 ready_s1;
	logic [23:0]          offset_s1;
	logic [63:0]          before_s1;
	logic [63:0]          after_s1;
	tsdf_pkg::scan_mode_t mode_s1;
	logic                 valid_s2;
	logic                 ready_s2;
	logic [23:0]          offset_s2;
	logic [63:0]          before_s2;
	logic [63:0]          after_s2;
	tsdf_pkg::scan_mode_t mode_s2;
	logic [63:0]          diff_ab_s2;
	logic [63:0]          diff_ba_s2;
	tsdf_pkg::cmp_flags_t flags_s2;
	logic                 match;
	logic                 valid_s3;
	logic [23:0]          offset_s3;
	logic [63:0]          before_s3;
	logic [63:0]          after_s3;

	tsdf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsdf_widen_stage u_widen (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.before_word    (before_word),
		.after_word     (after_word),
		.element_offset (element_offset),
		.cfg            (cfg),
		.next_ready     (ready_s1),
		.valid_s1       (valid_s1),
		.offset_s1      (offset_s1),
		.before_s1      (before_s1),
		.after_s1       (after_s1),
		.mode_s1        (mode_s1)
	);

	tsdf_compare_stage u_compare (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ready_s1   (ready_s1),
		.offset_s1  (offset_s1),
		.before_s1  (before_s1),
		.after_s1   (after_s1),
		.mode_s1    (mode_s1),
		.cfg        (cfg),
		.next_ready (ready_s2),
		.valid_s2   (valid_s2),
		.offset_s2  (offset_s2),
		.before_s2  (before_s2),
		.after_s2   (after_s2),
		.mode_s2    (mode_s2),
		.diff_ab_s2 (diff_ab_s2),
		.diff_ba_s2 (diff_ba_s2),
		.flags_s2   (flags_s2)
	);

	// The output register takes a beat when empty or being drained.
	assign ready_s2 = !valid_s3 || out_ready;

	// Pick the match condition of the item's scan mode.
	always_comb begin
		case (mode_s2)
			tsdf_pkg::MODE_CHANGED:    match = flags_s2.ne;
			tsdf_pkg::MODE_UNCHANGED:  match = !flags_s2.ne;
			tsdf_pkg::MODE_INCREASED:  match = flags_s2.gt;
			tsdf_pkg::MODE_DECREASED:  match = flags_s2.lt;
			tsdf_pkg::MODE_INC_BY:     match = (diff_ab_s2 == cfg.value_a);
			tsdf_pkg::MODE_DEC_BY:     match = (diff_ba_s2 == cfg.value_a);
			tsdf_pkg::MODE_EXACT:      match = flags_s2.eq_a;
			tsdf_pkg::MODE_RANGE:      match = flags_s2.ge_a && flags_s2.le_b;
			tsdf_pkg::MODE_MASK:       match = flags_s2.mask_ok;
			tsdf_pkg::MODE_STABILIZED: match = !flags_s2.ne;
			default:                   match = 1'b0;
		endcase
	end

	// Output valid; non-matching items become bubbles here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2 && match;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			offset_s3 <= offset_s2;
			before_s3 <= before_s2;
			after_s3  <= after_s2;
		end
	end

	assign out_valid      = valid_s3;
	assign match_offset   = offset_s3;
	assign widened_before = before_s3;
	assign widened_after  = after_s3;

endmodule

@@ bench/typed_snapshot_diff_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed snapshot diff filter testbench
// Streams before/after element pairs through the filter under a series of
// scan mode and data type settings. Each accepted element is widened and
// tested here as well, and every output beat is checked field by field
// against the oldest predicted match while both stream sides idle and stall.
// ----------------------------------------------------------------------------
module typed_snapshot_diff_filter_tb;
	import tsdf_pkg::*;

	// Codes the package leaves unnamed: the spare data type, the scan modes
	// that never match and the register indexes that hold nothing.
	localparam logic [2:0] DT_SPARE = 3'd7;
	localparam logic [3:0] MODE_NEVER_LO = 4'd10;
	localparam logic [3:0] MODE_NEVER_HI = 4'd15;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 15;
	localparam int PHASE_ITEMS = 32;
	localparam int PRESSURE_ITEMS = 40;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [31:0] before_raw;
		logic [31:0] after_raw;
		logic [23:0] offset;
	} element_t;

	typedef struct {
		logic [23:0] offset;
		logic [63:0] before_wide;
		logic [63:0] after_wide;
	} match_t;

	typedef struct {
		logic [3:0]  mode;
		logic [2:0]  dtype;
		logic [63:0] value_a;
		logic [63:0] value_b;
		logic [31:0] mask_bits;
		logic [31:0] pattern_bits;
	} filter_cfg_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [63:0]            cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [31:0]            before_word = '0;
	logic [31:0]            after_word = '0;
	logic [23:0]            element_offset = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [23:0]            match_offset;
	logic [63:0]            widened_before;
	logic [63:0]            widened_after;

	// Filter settings as the bench believes them to be; reset values first.
	filter_cfg_t active_cfg = '{MODE_CHANGED, DT_F32, 64'd0, 64'd0, 32'd0, 32'd0};

	element_t queued_elements[$];
	match_t   expected_matches[$];

	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int elements_sent = 0;
	int matches_seen = 0;
	int settings_used = 0;

	typed_snapshot_diff_filter uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.before_word    (before_word),
		.after_word     (after_word),
		.element_offset (element_offset),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_offset   (match_offset),
		.widened_before (widened_before),
		.widened_after  (widened_after)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bytes an element occupies; the spare type reads one byte.
	function automatic int element_size(input logic [2:0] dtype);
		case (dtype)
			DT_S16, DT_U16: return 2;
			DT_S32, DT_U32, DT_F32: return 4;
			default: return 1;
		endcase
	endfunction

	// Extends the raw element bytes to 64 bits; float keeps its raw bits.
	function automatic logic [63:0] widen_raw(input logic [31:0] raw, input logic [2:0] dtype);
		case (dtype)
			DT_S8: return {{56{raw[7]}}, raw[7:0]};
			DT_S16: return {{48{raw[15]}}, raw[15:0]};
			DT_U16: return {48'd0, raw[15:0]};
			DT_S32: return {{32{raw[31]}}, raw};
			DT_U32, DT_F32: return {32'd0, raw};
			default: return {56'd0, raw[7:0]};
		endcase
	endfunction

	// Scan mode test on the widened pair; undefined modes never pass.
	function automatic bit pair_passes(input logic [63:0] b, input logic [63:0] a);
		case (active_cfg.mode)
			MODE_CHANGED: return b != a;
			MODE_UNCHANGED, MODE_STABILIZED: return b == a;
			MODE_INCREASED: return a > b;
			MODE_DECREASED: return a < b;
			MODE_INC_BY: return (a - b) == active_cfg.value_a;
			MODE_DEC_BY: return (b - a) == active_cfg.value_a;
			MODE_EXACT: return a == active_cfg.value_a;
			MODE_RANGE: return a >= active_cfg.value_a && a <= active_cfg.value_b;
			MODE_MASK: return (a[31:0] & active_cfg.mask_bits) == active_cfg.pattern_bits;
			default: return 1'b0;
		endcase
	endfunction

	// Predicts whether an element leaves a beat, and which one.
	function automatic bit filter_element(input element_t el, output match_t hit);
		logic [33:0] end_byte;
		hit.offset = el.offset;
		hit.before_wide = widen_raw(el.before_raw, active_cfg.dtype);
		hit.after_wide = widen_raw(el.after_raw, active_cfg.dtype);
		end_byte = {10'd0, el.offset} + 34'(element_size(active_cfg.dtype));
		if (end_byte > {1'b0, REGION_BYTES})
			return 1'b0;
		return pair_passes(hit.before_wide, hit.after_wide);
	endfunction

	// Raw word: mostly random, sometimes a sign or width boundary.
	function automatic logic [31:0] pick_raw();
		if ($urandom_range(4) != 0)
			return $urandom;
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_007F;
			3: return 32'h0000_0080;
			4: return 32'h0000_00FF;
			5: return 32'h0000_7FFF;
			6: return 32'h0000_8000;
			7: return 32'h0000_FFFF;
			8: return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	// Random element, usually shaped so that the current mode can match.
	function automatic element_t shape_element();
		element_t el;
		logic [31:0] unused_bytes;
		el.before_raw = pick_raw();
		el.after_raw = pick_raw();
		if ($urandom_range(9) == 0)
			el.offset = 24'($urandom_range(24'hFFFFFF, 24'hFFFFF0));
		else
			el.offset = 24'($urandom);
		case (element_size(active_cfg.dtype))
			1: unused_bytes = 32'hFFFF_FF00;
			2: unused_bytes = 32'hFFFF_0000;
			default: unused_bytes = 32'h0000_0000;
		endcase
		if ($urandom_range(9) < 7) begin
			case (active_cfg.mode)
				MODE_CHANGED, MODE_UNCHANGED, MODE_STABILIZED: begin
					if ($urandom_range(1) != 0)
						el.after_raw = el.before_raw ^ ($urandom & unused_bytes);
				end
				MODE_INCREASED: el.after_raw = el.before_raw + $urandom_range(3);
				MODE_DECREASED: el.after_raw = el.before_raw - $urandom_range(3);
				MODE_INC_BY: el.after_raw = el.before_raw + active_cfg.value_a[31:0];
				MODE_DEC_BY: el.after_raw = el.before_raw - active_cfg.value_a[31:0];
				MODE_EXACT: begin
					el.after_raw = active_cfg.value_a[31:0] ^ ($urandom & unused_bytes);
					// First exact pass: the same word on both sides.
					if ($urandom_range(1) != 0)
						el.before_raw = el.after_raw;
				end
				MODE_RANGE: el.after_raw = active_cfg.value_a[31:0] + $urandom_range(3);
				MODE_MASK: el.after_raw = ($urandom & ~active_cfg.mask_bits)
						| (active_cfg.pattern_bits & active_cfg.mask_bits);
				default: ;
			endcase
		end
		return el;
	endfunction

	task automatic note_error(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
	endtask

	// One register write; the bench copy follows once the beat is taken.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SCAN_MODE: active_cfg.mode = data[3:0];
			REG_DATA_TYPE: active_cfg.dtype = data[2:0];
			REG_VALUE_A: active_cfg.value_a = data;
			REG_VALUE_B: active_cfg.value_b = data;
			REG_MASK_BITS: active_cfg.mask_bits = data[31:0];
			REG_PATTERN_BITS: active_cfg.pattern_bits = data[31:0];
			default: ;
		endcase
	endtask

	// Writes every register; unused upper data bits carry random noise.
	task automatic program_filter(input logic [3:0] mode, input logic [2:0] dtype,
			input logic [63:0] va, input logic [63:0] vb,
			input logic [31:0] mask, input logic [31:0] pattern);
		write_reg(REG_SCAN_MODE, {$urandom, 28'($urandom), mode});
		write_reg(REG_DATA_TYPE, {$urandom, 29'($urandom), dtype});
		write_reg(REG_VALUE_A, va);
		write_reg(REG_VALUE_B, vb);
		write_reg(REG_MASK_BITS, {$urandom, mask});
		write_reg(REG_PATTERN_BITS, {$urandom, pattern});
		settings_used++;
	endtask

	// Random settings for one phase; the first ten phases walk the modes.
	task automatic random_config(input int phase);
		logic [3:0]  mode;
		logic [2:0]  dtype;
		logic [63:0] va;
		logic [63:0] vb;
		logic [63:0] swap;
		logic [31:0] mask;
		logic [31:0] pattern;
		if (phase <= int'(MODE_STABILIZED))
			mode = 4'(phase);
		else if ($urandom_range(99) < 15)
			mode = 4'($urandom_range(MODE_NEVER_HI, MODE_NEVER_LO));
		else
			mode = 4'($urandom_range(MODE_STABILIZED));
		dtype = 3'($urandom_range(DT_SPARE));
		if (mode == MODE_INC_BY || mode == MODE_DEC_BY) begin
			case ($urandom_range(3))
				0, 1: va = 64'($urandom_range(4));
				2: va = '1;
				default: va = widen_raw(pick_raw(), dtype);
			endcase
		end else begin
			case ($urandom_range(6))
				0: va = '0;
				1: va = '1;
				2: va = {$urandom, $urandom};
				default: va = widen_raw(pick_raw(), dtype);
			endcase
		end
		case ($urandom_range(6))
			0: vb = '1;
			1: vb = '0;
			default: vb = widen_raw(pick_raw(), dtype);
		endcase
		// Mostly a proper range; now and then an empty one.
		if (mode == MODE_RANGE && va > vb && $urandom_range(4) != 0) begin
			swap = va;
			va = vb;
			vb = swap;
		end
		case ($urandom_range(5))
			0: mask = '0;
			1: mask = '1;
			default: mask = $urandom;
		endcase
		pattern = ($urandom_range(3) != 0) ? ($urandom & mask) : $urandom;
		program_filter(mode, dtype, va, vb, mask, pattern);
	endtask

	// Sets the idling of both sides away from the clock edge.
	task automatic set_idling(input int gap_pct, input int stall_rate);
		@(negedge clk);
		send_gap_pct = gap_pct;
		stall_pct = stall_rate;
	endtask

	task automatic queue_element(input logic [31:0] b, input logic [31:0] a,
			input logic [23:0] offset);
		element_t el;
		el.before_raw = b;
		el.after_raw = a;
		el.offset = offset;
		queued_elements = {queued_elements, el};
	endtask

	// Sender pauses until every predicted beat has arrived and the pipeline
	// has had time to retire elements that leave no beat.
	task automatic wait_drained();
		do @(negedge clk);
		while (queued_elements.size() != 0 || in_valid || expected_matches.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Element driver: predicts each accepted beat, then offers the next one.
	always @(posedge clk or negedge arst_n) begin : element_driver
		element_t offered;
		element_t next_el;
		match_t   hit;
		if (!arst_n) begin
			in_valid <= 1'b0;
			before_word <= '0;
			after_word <= '0;
			element_offset <= '0;
		end else begin
			if (in_valid && in_ready) begin
				offered.before_raw = before_word;
				offered.after_raw = after_word;
				offered.offset = element_offset;
				if (filter_element(offered, hit))
					expected_matches = {expected_matches, hit};
				elements_sent++;
			end
			if (!in_valid || in_ready) begin
				if (queued_elements.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_el = queued_elements.pop_front();
					in_valid <= 1'b1;
					before_word <= next_el.before_raw;
					after_word <= next_el.after_raw;
					element_offset <= next_el.offset;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long output hold, counted here and started by a token from the sequence.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_token) begin
			hold_left <= HOLD_CYCLES;
			hold_seen <= hold_token;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: each beat is compared with the oldest predicted match.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		match_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				matches_seen++;
				if (expected_matches.size() == 0) begin
					note_error($sformatf("unexpected beat: offset %h before %h after %h",
						match_offset, widened_before, widened_after));
				end else begin
					want = expected_matches.pop_front();
					if (match_offset !== want.offset || widened_before !== want.before_wide
							|| widened_after !== want.after_wide)
						note_error($sformatf(
							"mismatch: offset %h/%h before %h/%h after %h/%h (exp/got)",
							want.offset, match_offset, want.before_wide, widened_before,
							want.after_wide, widened_after));
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on cycles in which no beat of any channel is taken.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat taken for %0d cycles, %0d matches outstanding.",
				quiet_cycles, expected_matches.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Test sequence.
	initial begin : sequence_run
		logic [31:0] word;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: changed mode on float raw bits, up to the region end.
		set_idling(0, 0);
		queue_element(32'h0000_0000, 32'hFFFF_FFFF, 24'h000000);
		queue_element(32'h1234_5678, 32'h1234_5678, 24'hFFFFFC);
		queue_element(32'h0000_0000, 32'h0000_0001, 24'hFFFFFD);
		queue_element(32'h0000_0000, 32'h0000_0001, 24'hFFFFFC);
		wait_drained();

		// Signed byte: unused high bytes are ignored; last byte of the region.
		program_filter(MODE_UNCHANGED, DT_S8, '0, '0, '0, '0);
		queue_element(32'h0000_0080, 32'hFFFF_FF80, 24'h000010);
		queue_element(32'h0000_007F, 32'h0000_0080, 24'hFFFFFF);
		queue_element(32'hAB00_0080, 32'h0000_0080, 24'hFFFFFF);
		wait_drained();

		// Signed halfword: a negative value compares above as unsigned.
		program_filter(MODE_INCREASED, DT_S16, '0, '0, '0, '0);
		queue_element(32'h0000_7FFF, 32'h0000_8000, 24'hFFFFFE);
		queue_element(32'h0000_0000, 32'h0000_0001, 24'hFFFFFF);
		wait_drained();

		program_filter(MODE_DECREASED, DT_U16, '0, '0, '0, '0);
		queue_element(32'h0000_8000, 32'h0000_7FFF, 24'h000002);
		queue_element(32'hFFFF_0001, 32'h0000_0002, 24'h000006);
		wait_drained();

		// Increase by one on unaligned offsets.
		program_filter(MODE_INC_BY, DT_S32, 64'd1, '0, '0, '0);
		queue_element(32'h7FFF_FFFF, 32'h8000_0000, 24'h000007);
		queue_element(32'h0000_0005, 32'h0000_0006, 24'h000007);
		wait_drained();

		// Decrease by all ones: the difference wraps.
		program_filter(MODE_DEC_BY, DT_U32, '1, '0, '0, '0);
		queue_element(32'h0000_0000, 32'h0000_0001, 24'h000008);
		queue_element(32'hFFFF_FFFF, 32'h0000_0000, 24'h000000);
		wait_drained();

		// First exact pass feeds the same word twice.
		program_filter(MODE_EXACT, DT_U8, 64'hFF, '0, '0, '0);
		queue_element(32'h0000_00FF, 32'h0000_00FF, 24'h000003);
		queue_element(32'hABCD_EFFF, 32'hABCD_EFFF, 24'h000005);
		wait_drained();

		// Spare data type reads as an unsigned byte; both range bounds.
		program_filter(MODE_RANGE, DT_SPARE, 64'h10, 64'h20, '0, '0);
		queue_element(32'h0000_0000, 32'h0000_0010, 24'h000000);
		queue_element(32'h0000_0000, 32'h0000_0020, 24'h000001);
		queue_element(32'h0000_0000, 32'h0000_0021, 24'h000002);
		queue_element(32'h0000_0000, 32'h0000_0115, 24'h000003);
		wait_drained();

		// Mask mode looks at the low 32 bits of the widened value only.
		program_filter(MODE_MASK, DT_S32, '0, '0, 32'hF000_000F, 32'h8000_000F);
		queue_element(32'h0000_0000, 32'h8000_000F, 24'h000003);
		queue_element(32'h0000_0000, 32'h0000_000F, 24'h000004);
		wait_drained();

		// Extreme register values, and writes to the unused indexes.
		program_filter(MODE_STABILIZED, DT_F32, '0, '1, '1, '1);
		write_reg(REG_SPARE_LO, {$urandom, $urandom});
		write_reg(REG_SPARE_HI, {$urandom, $urandom});
		set_idling(0, 0);
		queue_element(32'h3F80_0000, 32'h3F80_0000, 24'h000020);
		wait_drained();

		// An undefined scan mode never matches.
		program_filter(MODE_NEVER_HI, DT_F32, '0, '0, '0, '0);
		queue_element(32'h0000_0001, 32'h0000_0002, 24'h000000);
		queue_element(32'h0000_0001, 32'h0000_0001, 24'h000000);
		wait_drained();

		// Random phases, cycling through the idling profiles.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config(phase);
			case (phase % 4)
				0: set_idling(0, 0);
				1: set_idling(60, 0);
				2: set_idling(0, 60);
				default: set_idling(13, 13);
			endcase
			repeat (PHASE_ITEMS)
				queued_elements = {queued_elements, shape_element()};
			wait_drained();
		end

		// Output held off while the sender runs at full rate: every element
		// matches, so the pipeline fills and in_ready drops.
		program_filter(MODE_CHANGED, DT_U32, {$urandom, $urandom}, '1, $urandom, $urandom);
		set_idling(0, 0);
		hold_token = hold_token + 1;
		repeat (PRESSURE_ITEMS) begin
			word = $urandom;
			queue_element(word, ~word, 24'($urandom_range(24'hFFFFF0)));
		end
		wait_drained();

		$display("Run covered %0d elements and %0d result beats over %0d filter settings,",
			elements_sent, matches_seen, settings_used);
		$display("all scan mode and data type codes, the region end and a long output hold.");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
